/* sv/cgcw_pkg.sv */
// Shared types, codes and lookup functions for the character-cell store.
package cgcw_pkg;

  // Default grid size
  localparam int unsigned COLS_DEF = 128;
  localparam int unsigned ROWS_DEF = 64;

  // Column arithmetic width: holds column + 2 and compares against up to 256 columns
  localparam int unsigned COL_EXT_W = 9;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 7;

  localparam logic [CFG_IDX_W-1:0] CFG_WIDE_ENABLE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CLIP_LEFT   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CLIP_RIGHT  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CLIP_TOP    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_CLIP_BOTTOM = 3'd4;

  // Request opcodes
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_READ  = 1'b1;

  // Cell width codes
  localparam logic [1:0] W_CONT = 2'd0;
  localparam logic [1:0] W_NORM = 2'd1;
  localparam logic [1:0] W_WIDE = 2'd2;

  localparam logic [20:0] GLYPH_SPACE = 21'h20;

  // One stored cell
  typedef struct packed {
    logic [20:0] glyph;
    logic [1:0]  width;
    logic [31:0] fore;
    logic [31:0] back;
    logic        back_def;
    logic [6:0]  attrs;
  } cell_t;

  localparam cell_t BLANK_CELL = '{
    glyph:    GLYPH_SPACE,
    width:    W_NORM,
    fore:     32'h0,
    back:     32'h0,
    back_def: 1'b1,
    attrs:    7'h0
  };

  // Wide-glyph ranges, both bounds included
  localparam int unsigned N_WIDE = 22;

  localparam logic [20:0] WIDE_LO [N_WIDE] = '{
    21'h01100, 21'h02E80, 21'h03041, 21'h03400, 21'h04E00, 21'h0A000,
    21'h0AC00, 21'h0F900, 21'h0FE30, 21'h0FF00, 21'h0FFE0, 21'h1F004,
    21'h1F0CF, 21'h1F18E, 21'h1F191, 21'h1F200, 21'h1F210, 21'h1F240,
    21'h1F250, 21'h1F260, 21'h1F300, 21'h20000
  };

  localparam logic [20:0] WIDE_HI [N_WIDE] = '{
    21'h0115F, 21'h0303E, 21'h033FF, 21'h04DBF, 21'h09FFF, 21'h0A4CF,
    21'h0D7A3, 21'h0FAFF, 21'h0FE4F, 21'h0FF60, 21'h0FFE6, 21'h1F004,
    21'h1F0CF, 21'h1F18E, 21'h1F19A, 21'h1F202, 21'h1F23B, 21'h1F248,
    21'h1F251, 21'h1F265, 21'h1FAFF, 21'h3FFFD
  };

  // True when the code point lies in any wide range
  function automatic logic is_wide(input logic [20:0] cp);
    logic hit;
    hit = 1'b0;
    for (int i = 0; i < N_WIDE; i++) begin
      hit = hit | ((cp >= WIDE_LO[i]) && (cp <= WIDE_HI[i]));
    end
    return hit;
  endfunction

  // C0, DEL, C1 and the line and paragraph separators
  function automatic logic is_ctrl(input logic [20:0] cp);
    return (cp < 21'h20) || (cp == 21'h7F) || ((cp >= 21'h80) && (cp <= 21'h9F)) ||
           (cp == 21'h2028) || (cp == 21'h2029);
  endfunction

endpackage

/* sv/cell_grid_cluster_write.sv */
// Character-cell store top level: cell memory, read-modify-write sequencer, config registers.
//
// A COLS x ROWS grid of terminal cells held in one synchronous memory (one write and one
// read port, registered read data). After reset the block sweeps the memory to blank cells,
// one entry a cycle, over all COLS*ROWS entries (8192 at the default size); during the sweep no
// request is taken, while configuration writes are taken at any time. A request is taken
// only when the sequencer is idle, one at a time. A read issues a single memory read, waits
// for the data and then posts the result; for an in-grid write the sequencer reads the cells
// at column-1 to column+2 one after another, waits for the last read, writes them back one a
// cycle and then posts the result. Refused writes, zero-width clusters and reads outside the
// grid skip the memory and post the result directly. A finished result waits in an output
// register, so the next request can be accepted before the previous result is taken.
module cell_grid_cluster_write #(
  parameter int unsigned COLS = cgcw_pkg::COLS_DEF,
  parameter int unsigned ROWS = cgcw_pkg::ROWS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // Configuration write channel
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [cgcw_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [cgcw_pkg::CFG_DATA_W-1:0] cfg_data_i,
  // Request channel
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic                           opcode_i,
  input  logic [6:0]                     column_i,
  input  logic [5:0]                     line_i,
  input  logic [20:0]                    code_point_i,
  input  logic                           all_zero_width_i,
  input  logic                           flag_pair_i,
  input  logic                           has_vs16_i,
  input  logic [31:0]                    fore_colour_i,
  input  logic [31:0]                    back_colour_i,
  input  logic                           back_default_i,
  input  logic [6:0]                     attr_bits_i,
  // Result channel
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [1:0]                     columns_used_o,
  output logic                           was_written_o,
  output logic [20:0]                    read_glyph_o,
  output logic [1:0]                     read_width_o,
  output logic [31:0]                    read_fore_o,
  output logic [31:0]                    read_back_o,
  output logic                           read_back_default_o,
  output logic [6:0]                     read_attrs_o
);

  localparam int unsigned DEPTH = COLS * ROWS;
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned XW    = cgcw_pkg::COL_EXT_W;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_WAIT,
    ST_WRITE,
    ST_DONE
  } state_e;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic       wide_en_q;
  logic [6:0] clip_l_q, clip_r_q;
  logic [5:0] clip_t_q, clip_b_q;

  assign cfg_ready_o = 1'b1;

  // Decode and hold register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wide_en_q <= 1'b1;
      clip_l_q  <= 7'd0;
      clip_r_q  <= 7'd127;
      clip_t_q  <= 6'd0;
      clip_b_q  <= 6'd63;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        cgcw_pkg::CFG_WIDE_ENABLE: wide_en_q <= cfg_data_i[0];
        cgcw_pkg::CFG_CLIP_LEFT:   clip_l_q  <= cfg_data_i[6:0];
        cgcw_pkg::CFG_CLIP_RIGHT:  clip_r_q  <= cfg_data_i[6:0];
        cgcw_pkg::CFG_CLIP_TOP:    clip_t_q  <= cfg_data_i[5:0];
        cgcw_pkg::CFG_CLIP_BOTTOM: clip_b_q  <= cfg_data_i[5:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Request decode at acceptance
  // ---------------------------------------------------------------------------
  state_e state_q;
  logic   accept;

  logic [XW-1:0] x_ext, x1_ext, y_ext;
  logic          in_buf_d, clip_y, tgt_ok_d, nxt_ok_d;
  logic [1:0]    w_d;
  logic [AW-1:0] base_d;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  // Classify the target cell, its right neighbor and the cluster width
  always_comb begin
    x_ext    = XW'(column_i);
    x1_ext   = x_ext + XW'(1);
    y_ext    = XW'(line_i);
    in_buf_d = (x_ext < XW'(COLS)) && (y_ext < XW'(ROWS));
    clip_y   = (line_i >= clip_t_q) && (line_i <= clip_b_q);
    tgt_ok_d = in_buf_d && clip_y && (column_i >= clip_l_q) && (column_i <= clip_r_q);
    nxt_ok_d = (x1_ext < XW'(COLS)) && (y_ext < XW'(ROWS)) && clip_y &&
               (x1_ext >= XW'(clip_l_q)) && (x1_ext <= XW'(clip_r_q));
    if (all_zero_width_i) begin
      w_d = cgcw_pkg::W_CONT;
    end else if (!wide_en_q) begin
      w_d = cgcw_pkg::W_NORM;
    end else if (cgcw_pkg::is_wide(code_point_i) || flag_pair_i || has_vs16_i) begin
      w_d = cgcw_pkg::W_WIDE;
    end else begin
      w_d = cgcw_pkg::W_NORM;
    end
    base_d = AW'(int'(line_i) * COLS);
  end

  // ---------------------------------------------------------------------------
  // Request and neighbor-cell holding registers
  // ---------------------------------------------------------------------------
  logic          op_q, in_buf_q, tgt_ok_q, nxt_ok_q, bdef_q;
  logic [6:0]    x_q, attrs_q;
  logic [AW-1:0] base_q;
  logic [1:0]    w_q;
  logic [20:0]   cp_q;
  logic [31:0]   fg_q, bgw_q;

  cgcw_pkg::cell_t slot_q [4];
  cgcw_pkg::cell_t rd_data_q;
  logic            rd_pend_q;
  logic [1:0]      rd_slot_q;

  // Capture the request and returning read data
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q     <= opcode_i;
      x_q      <= column_i;
      base_q   <= base_d;
      in_buf_q <= in_buf_d;
      tgt_ok_q <= tgt_ok_d;
      nxt_ok_q <= nxt_ok_d;
      w_q      <= w_d;
      cp_q     <= code_point_i;
      fg_q     <= fore_colour_i;
      bgw_q    <= back_colour_i;
      bdef_q   <= back_default_i;
      attrs_q  <= attr_bits_i;
    end
    if (rd_pend_q) begin
      slot_q[rd_slot_q] <= rd_data_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Address of the current neighbor slot (column - 1 + slot)
  // ---------------------------------------------------------------------------
  logic [1:0]    cnt_q, last_q;
  logic [XW-1:0] cur_col;
  logic [AW-1:0] cur_addr;

  always_comb begin
    cur_col = XW'(x_q) + XW'(cnt_q) - XW'(1);
    if (cur_col < XW'(COLS)) begin
      cur_addr = base_q + AW'(cur_col);
    end else begin
      cur_addr = base_q + AW'(x_q);
    end
  end

  // ---------------------------------------------------------------------------
  // Neighbor update: partner clearing, wide lead and continuation
  // ---------------------------------------------------------------------------
  logic            a_ok, b_ok, c_ok, is_w2, edge_wide;
  logic            d1_a, d1_t, d1_b, d2_t, d2_b, d2_c;
  cgcw_pkg::cell_t t1, b1, t2, t_new, b_new;
  logic [31:0]     bg_word;
  logic            bg_def;
  cgcw_pkg::cell_t wcell [4];
  logic [3:0]      wen;

  always_comb begin
    a_ok      = (x_q != 7'd0);
    b_ok      = (XW'(x_q) + XW'(1)) < XW'(COLS);
    c_ok      = (XW'(x_q) + XW'(2)) < XW'(COLS);
    is_w2     = (w_q == cgcw_pkg::W_WIDE);
    edge_wide = is_w2 && !nxt_ok_q;

    // Drop the partner of the target cell
    d1_t = (slot_q[1].width == cgcw_pkg::W_CONT) && a_ok;
    d1_a = d1_t && (slot_q[0].width == cgcw_pkg::W_WIDE);
    d1_b = (slot_q[1].width == cgcw_pkg::W_WIDE) && b_ok &&
           (slot_q[2].width == cgcw_pkg::W_CONT);
    t1   = d1_t ? cgcw_pkg::BLANK_CELL : slot_q[1];
    b1   = d1_b ? cgcw_pkg::BLANK_CELL : slot_q[2];

    // Drop the partner of the right cell for a wide cluster
    d2_b = is_w2 && !edge_wide && (b1.width == cgcw_pkg::W_CONT);
    d2_t = d2_b && (t1.width == cgcw_pkg::W_WIDE);
    d2_c = is_w2 && !edge_wide && (b1.width == cgcw_pkg::W_WIDE) && c_ok &&
           (slot_q[3].width == cgcw_pkg::W_CONT);
    t2   = d2_t ? cgcw_pkg::BLANK_CELL : t1;

    // Keep the settled background on a default-kind request
    bg_word = bdef_q ? t2.back : bgw_q;
    bg_def  = bdef_q ? t2.back_def : 1'b0;

    // New target and right cells
    if (edge_wide) begin
      t_new.glyph    = cgcw_pkg::GLYPH_SPACE;
      t_new.width    = cgcw_pkg::W_NORM;
      t_new.back     = bdef_q ? 32'h0 : bgw_q;
      t_new.back_def = bdef_q;
    end else begin
      t_new.glyph    = cgcw_pkg::is_ctrl(cp_q) ? cgcw_pkg::GLYPH_SPACE : cp_q;
      t_new.width    = w_q;
      t_new.back     = bg_word;
      t_new.back_def = bg_def;
    end
    t_new.fore  = fg_q;
    t_new.attrs = attrs_q;

    if (is_w2 && !edge_wide) begin
      b_new = '{glyph: 21'h0, width: cgcw_pkg::W_CONT, fore: fg_q, back: bg_word,
                back_def: bg_def, attrs: attrs_q};
    end else begin
      b_new = cgcw_pkg::BLANK_CELL;
    end

    wcell[0] = cgcw_pkg::BLANK_CELL;
    wcell[1] = t_new;
    wcell[2] = b_new;
    wcell[3] = cgcw_pkg::BLANK_CELL;
    wen[0]   = d1_a;
    wen[1]   = 1'b1;
    wen[2]   = d1_b || (is_w2 && !edge_wide);
    wen[3]   = d2_c;
  end

  // ---------------------------------------------------------------------------
  // Cell memory
  // ---------------------------------------------------------------------------
  cgcw_pkg::cell_t cell_mem [DEPTH];
  logic            mem_we;
  logic [AW-1:0]   mem_waddr;
  cgcw_pkg::cell_t mem_wdata;
  logic [AW-1:0]   clr_q;

  always_comb begin
    if (state_q == ST_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_q;
      mem_wdata = cgcw_pkg::BLANK_CELL;
    end else begin
      mem_we    = (state_q == ST_WRITE) && wen[cnt_q];
      mem_waddr = cur_addr;
      mem_wdata = wcell[cnt_q];
    end
  end

  // Write at most one entry and read one entry each cycle
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      cell_mem[mem_waddr] <= mem_wdata;
    end
    rd_data_q <= cell_mem[cur_addr];
  end

  // ---------------------------------------------------------------------------
  // Sequencer and result register
  // ---------------------------------------------------------------------------
  logic [1:0]  columns_used_q;
  logic        out_valid_q, was_written_q;
  cgcw_pkg::cell_t rcell;
  logic        rd_res;

  always_comb begin
    rd_res = (op_q == cgcw_pkg::OP_READ);
    rcell  = in_buf_q ? slot_q[1] : cgcw_pkg::BLANK_CELL;
  end

  cgcw_pkg::cell_t out_cell_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_CLEAR;
      clr_q          <= '0;
      cnt_q          <= 2'd0;
      last_q         <= 2'd0;
      rd_pend_q      <= 1'b0;
      rd_slot_q      <= 2'd0;
      out_valid_q    <= 1'b0;
      columns_used_q <= 2'd0;
      was_written_q  <= 1'b0;
      out_cell_q     <= '0;
    end else begin
      rd_pend_q <= (state_q == ST_READ);
      // Raise the result when posted, drop it once taken
      if ((state_q == ST_DONE) && (!out_valid_q || out_ready_i)) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_CLEAR: begin
          clr_q <= clr_q + AW'(1);
          if (clr_q == AW'(DEPTH - 1)) begin
            state_q <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            if (opcode_i == cgcw_pkg::OP_READ) begin
              cnt_q   <= 2'd1;
              last_q  <= 2'd1;
              state_q <= in_buf_d ? ST_READ : ST_DONE;
            end else begin
              cnt_q   <= 2'd0;
              last_q  <= 2'd3;
              state_q <= (tgt_ok_d && (w_d != cgcw_pkg::W_CONT)) ? ST_READ : ST_DONE;
            end
          end
        end
        ST_READ: begin
          rd_slot_q <= cnt_q;
          if (cnt_q == last_q) begin
            state_q <= ST_WAIT;
          end else begin
            cnt_q <= cnt_q + 2'd1;
          end
        end
        ST_WAIT: begin
          cnt_q   <= 2'd0;
          state_q <= rd_res ? ST_DONE : ST_WRITE;
        end
        ST_WRITE: begin
          cnt_q <= cnt_q + 2'd1;
          if (cnt_q == 2'd3) begin
            state_q <= ST_DONE;
          end
        end
        ST_DONE: begin
          // Hold until the result register is free
          if (!out_valid_q || out_ready_i) begin
            state_q <= ST_IDLE;
            if (rd_res) begin
              columns_used_q <= 2'd0;
              was_written_q  <= 1'b0;
              out_cell_q     <= rcell;
            end else if (tgt_ok_q && (w_q != cgcw_pkg::W_CONT)) begin
              columns_used_q <= w_q;
              was_written_q  <= 1'b1;
              out_cell_q     <= '0;
            end else begin
              columns_used_q <= 2'd0;
              was_written_q  <= 1'b0;
              out_cell_q     <= '0;
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_valid_o         = out_valid_q;
  assign columns_used_o      = columns_used_q;
  assign was_written_o       = was_written_q;
  assign read_glyph_o        = out_cell_q.glyph;
  assign read_width_o        = out_cell_q.width;
  assign read_fore_o         = out_cell_q.fore;
  assign read_back_o         = out_cell_q.back;
  assign read_back_default_o = out_cell_q.back_def;
  assign read_attrs_o        = out_cell_q.attrs;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_mem_we_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (state_q == ST_WRITE) || (state_q == ST_CLEAR))
    else $error("cell memory written outside the write or clear phase");

  a_rd_pend_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_pend_q |-> $past(state_q == ST_READ))
    else $error("read data captured without a read issued");

  a_accept_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q != ST_IDLE))
    else $error("accepted request did not start the sequencer");

  a_zero_width_unwritten: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (columns_used_o == cgcw_pkg::W_CONT)) |-> !was_written_o)
    else $error("write reported with zero columns");

  a_written_no_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && was_written_o) |-> (read_width_o == 2'd0) && (read_glyph_o == 21'h0))
    else $error("write result carries read cell fields");

endmodule
